// ----- sv/wsat_pkg.sv -----
// shared types and constants for the station address tracker
`timescale 1ns / 1ps

package wsat_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned RSSI_W = 8;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned TOT_W  = 6;
  localparam int unsigned GROUP_BIT = 40;

  localparam logic [11:0] MIN_FRAME_LEN = 12'd24;

  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] KIND_MGMT = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;

  localparam logic [2:0] EV_IGNORED   = 3'd0;
  localparam logic [2:0] EV_ADDED     = 3'd1;
  localparam logic [2:0] EV_REFRESHED = 3'd2;
  localparam logic [2:0] EV_FULL      = 3'd3;
  localparam logic [2:0] EV_READ      = 3'd4;
  localparam logic [2:0] EV_CLEARED   = 3'd5;

  // token that walks the cell row; ev starts as full for a lookup still open
  typedef struct packed {
    logic [2:0]        ev;
    logic [ADDR_W-1:0] addr;
    logic [RSSI_W-1:0] rssi;
    logic [IDX_W-1:0]  idx;
    logic              ent_valid;
  } tok_t;

endpackage

// ----- sv/wlan_station_address_tracker.sv -----
// top level of the station address tracker: decode stage, cell row, result register
//
// Input channel (in_valid_i / in_ready_o) carries one command per transfer:
// observe a parsed frame header, read one table entry, or clear the table.
// Output channel (out_valid_o / out_ready_i) returns exactly one result per
// command. target_bssid is written through cfg_we_i / cfg_wdata_i; the user
// must do so only while idle, as the block itself does not enforce it.
// An accepted item is decoded into a token, registered in the head stage,
// then walks the row of MAX_STATIONS cells, one cell per cycle while the row
// is not frozen, and lands in the result register. One item is in flight at
// a time; the next one is accepted the cycle after its predecessor reaches
// the result register. A stalled receiver holds the result; a token that
// reaches the end of the row meanwhile freezes the whole row until the
// result register frees up. Reset clears the station count and target_bssid;
// the entries themselves are not cleared, since only entries below the count
// are ever looked at.
`timescale 1ns / 1ps

module wlan_station_address_tracker import wsat_pkg::*; #(
  parameter int unsigned MAX_STATIONS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ADDR_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic [1:0]               frame_kind_i,
  input  logic [11:0]              frame_length_i,
  input  logic                     to_ds_i,
  input  logic                     from_ds_i,
  input  logic [ADDR_W-1:0]        address_one_i,
  input  logic [ADDR_W-1:0]        address_two_i,
  input  logic [ADDR_W-1:0]        address_three_i,
  input  logic signed [RSSI_W-1:0] signal_strength_i,
  input  logic [IDX_W-1:0]         read_index_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               event_res_o,
  output logic [ADDR_W-1:0]        station_address_o,
  output logic signed [RSSI_W-1:0] station_strength_o,
  output logic                     entry_valid_o,
  output logic [TOT_W-1:0]         station_total_o
);

  localparam int unsigned CntW = $clog2(MAX_STATIONS + 1);

  logic [ADDR_W-1:0] target_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   count_d;
  logic              busy_q;
  logic              out_valid_q;
  tok_t              out_tok_q;
  logic [TOT_W-1:0]  total_q;
  logic              head_vld_q;
  tok_t              head_tok_q;
  tok_t              dec_tok;
  logic              accept;
  logic              adv;
  logic              load;

  tok_t              chain_tok [MAX_STATIONS+1];
  logic [MAX_STATIONS:0] chain_vld;

  wsat_decode u_decode (
    .cmd_i             (cmd_i),
    .frame_kind_i      (frame_kind_i),
    .frame_length_i    (frame_length_i),
    .to_ds_i           (to_ds_i),
    .from_ds_i         (from_ds_i),
    .address_one_i     (address_one_i),
    .address_two_i     (address_two_i),
    .address_three_i   (address_three_i),
    .signal_strength_i ($unsigned(signal_strength_i)),
    .read_index_i      (read_index_i),
    .target_bssid_i    (target_q),
    .tok_o             (dec_tok)
  );

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;

  // the row only freezes when a finished token cannot leave
  assign adv  = !(chain_vld[MAX_STATIONS] && out_valid_q && !out_ready_i);
  assign load = chain_vld[MAX_STATIONS] && adv;

  assign chain_vld[0] = head_vld_q;
  assign chain_tok[0] = head_tok_q;

  for (genvar i = 0; i < MAX_STATIONS; i++) begin : g_cell
    wsat_cell #(
      .CellIdx (i),
      .CntW    (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .count_i (count_q),
      .vld_i   (chain_vld[i]),
      .tok_i   (chain_tok[i]),
      .vld_o   (chain_vld[i+1]),
      .tok_o   (chain_tok[i+1])
    );
  end

  always_comb begin
    count_d = count_q;
    if (load) begin
      priority if (chain_tok[MAX_STATIONS].ev == EV_ADDED) begin
        count_d = count_q + CntW'(1);
      end else if (chain_tok[MAX_STATIONS].ev == EV_CLEARED) begin
        count_d = '0;
      end else begin
        count_d = count_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      head_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        head_vld_q <= accept;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      head_tok_q <= dec_tok;
    end
    if (load) begin
      out_tok_q <= chain_tok[MAX_STATIONS];
      total_q   <= TOT_W'(count_d);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign event_res_o        = (out_tok_q.ev == EV_FULL || out_tok_q.ev == EV_ADDED ||
                               out_tok_q.ev == EV_REFRESHED || out_tok_q.ev == EV_READ ||
                               out_tok_q.ev == EV_CLEARED) ? out_tok_q.ev : EV_IGNORED;
  assign station_address_o  = out_tok_q.addr;
  assign station_strength_o = $signed(out_tok_q.rssi);
  assign entry_valid_o      = out_tok_q.ent_valid;
  assign station_total_o    = total_q;

  // count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_STATIONS))
    else $error("station count above table size");

  // at most one token in the decode stage and the cell row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld) <= 1)
    else $error("more than one token in flight");

  // a token in flight always means the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_vld != '0) |-> busy_q)
    else $error("token in flight while idle");

  // an append only happens with a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && chain_tok[MAX_STATIONS].ev == EV_ADDED) |-> (count_q < CntW'(MAX_STATIONS)))
    else $error("append into a full table");

  // entry_valid only comes with a read answer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_valid_o) |-> (event_res_o == EV_READ))
    else $error("entry_valid outside a read answer");

endmodule

// ----- sv/wsat_decode.sv -----
// header checks and address selection that turn one input item into a token
`timescale 1ns / 1ps

module wsat_decode import wsat_pkg::*; (
  input  logic [1:0]        cmd_i,
  input  logic [1:0]        frame_kind_i,
  input  logic [11:0]       frame_length_i,
  input  logic              to_ds_i,
  input  logic              from_ds_i,
  input  logic [ADDR_W-1:0] address_one_i,
  input  logic [ADDR_W-1:0] address_two_i,
  input  logic [ADDR_W-1:0] address_three_i,
  input  logic [RSSI_W-1:0] signal_strength_i,
  input  logic [IDX_W-1:0]  read_index_i,
  input  logic [ADDR_W-1:0] target_bssid_i,
  output tok_t              tok_o
);

  logic [ADDR_W-1:0] bssid;
  logic [ADDR_W-1:0] sta;
  logic              ds_ok;
  logic              frame_ok;
  logic              sta_ok;

  always_comb begin
    ds_ok = 1'b1;
    unique case ({to_ds_i, from_ds_i})
      2'b00: begin
        bssid = address_three_i;
        sta   = (address_two_i != target_bssid_i) ? address_two_i : address_one_i;
      end
      2'b10: begin
        bssid = address_one_i;
        sta   = address_two_i;
      end
      2'b01: begin
        bssid = address_two_i;
        sta   = address_one_i;
      end
      default: begin
        // four-address frame
        ds_ok = 1'b0;
        bssid = address_three_i;
        sta   = address_two_i;
      end
    endcase
  end

  assign frame_ok = (frame_kind_i == KIND_MGMT || frame_kind_i == KIND_DATA) &&
                    (frame_length_i >= MIN_FRAME_LEN);
  assign sta_ok = !sta[GROUP_BIT] && (sta != '0) && (sta != target_bssid_i);

  always_comb begin
    tok_o.ev        = EV_IGNORED;
    tok_o.addr      = '0;
    tok_o.rssi      = '0;
    tok_o.idx       = read_index_i;
    tok_o.ent_valid = 1'b0;
    unique case (cmd_i)
      CMD_OBSERVE: begin
        if (frame_ok && ds_ok && (bssid == target_bssid_i) && sta_ok) begin
          tok_o.ev   = EV_FULL;
          tok_o.addr = sta;
          tok_o.rssi = signal_strength_i;
        end
      end
      CMD_READ:  tok_o.ev = EV_READ;
      CMD_CLEAR: tok_o.ev = EV_CLEARED;
      default:   tok_o.ev = EV_IGNORED;
    endcase
  end

endmodule

// ----- sv/wsat_cell.sv -----
// one table entry: compares, appends or answers a read as the token passes
`timescale 1ns / 1ps

module wsat_cell import wsat_pkg::*; #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned CntW    = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [CntW-1:0] count_i,
  input  logic            vld_i,
  input  tok_t            tok_i,
  output logic            vld_o,
  output tok_t            tok_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(CellIdx);
  localparam bit Readable = (CellIdx < (1 << IDX_W));

  logic [ADDR_W-1:0] addr_q;
  logic [RSSI_W-1:0] rssi_q;
  logic              vld_q;
  tok_t              tok_q;
  tok_t              tok_d;
  logic              occupied;
  logic              is_tail;
  logic              wr_addr;
  logic              wr_rssi;

  assign occupied = MyIdx < count_i;
  assign is_tail  = MyIdx == count_i;

  always_comb begin
    tok_d   = tok_i;
    wr_addr = 1'b0;
    wr_rssi = 1'b0;
    if (vld_i) begin
      priority if (tok_i.ev == EV_FULL && occupied && addr_q == tok_i.addr) begin
        tok_d.ev = EV_REFRESHED;
        wr_rssi  = 1'b1;
      end else if (tok_i.ev == EV_FULL && is_tail) begin
        // first free slot, earlier cells already missed
        tok_d.ev = EV_ADDED;
        wr_addr  = 1'b1;
        wr_rssi  = 1'b1;
      end else if (tok_i.ev == EV_READ && Readable && occupied &&
                   tok_i.idx == IDX_W'(CellIdx)) begin
        tok_d.addr      = addr_q;
        tok_d.rssi      = rssi_q;
        tok_d.ent_valid = 1'b1;
      end else begin
        tok_d = tok_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
      if (wr_addr) begin
        addr_q <= tok_i.addr;
      end
      if (wr_rssi) begin
        rssi_q <= tok_i.rssi;
      end
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

// ----- tb/testbench.sv -----
// testbench for the station address tracker: directed and random traffic with a scoreboard
`timescale 1ns / 1ps

module testbench;
  import wsat_pkg::*;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned POOL_SIZE   = 40;
  localparam int unsigned PHASE_ITEMS = 170;

  // codes the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [1:0]               kind;
    logic [11:0]              length;
    logic                     to_ds;
    logic                     from_ds;
    logic [ADDR_W-1:0]        addr_one;
    logic [ADDR_W-1:0]        addr_two;
    logic [ADDR_W-1:0]        addr_three;
    logic signed [RSSI_W-1:0] rssi;
    logic [IDX_W-1:0]         index;
  } frame_cmd_t;

  typedef struct packed {
    logic [2:0]               ev;
    logic [ADDR_W-1:0]        addr;
    logic signed [RSSI_W-1:0] rssi;
    logic                     valid;
    logic [TOT_W-1:0]         total;
  } tracker_result_t;

  class station_table_scoreboard;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] addr_tab [TABLE_DEPTH];
    logic [RSSI_W-1:0] rssi_tab [TABLE_DEPTH];
    int unsigned       count;
    tracker_result_t   expected_q [$];
    int unsigned       failures;
    int unsigned       transfers;
    int unsigned       ev_seen [8];
    int unsigned       valid_reads;

    function new();
      target = '0;
      count = 0;
      failures = 0;
      transfers = 0;
      valid_reads = 0;
      foreach (ev_seen[i]) ev_seen[i] = 0;
      foreach (addr_tab[i]) begin
        addr_tab[i] = '0;
        rssi_tab[i] = '0;
      end
    endfunction

    function void set_target(input logic [ADDR_W-1:0] value);
      target = value;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    // one transfer: header decode, bssid and station checks, then table update; or a read or a clear
    function void note_transfer(input frame_cmd_t c);
      tracker_result_t r;
      logic [ADDR_W-1:0] bssid;
      logic [ADDR_W-1:0] sta;
      bit usable;
      bit found;
      r = '0;
      r.ev = EV_IGNORED;
      transfers++;
      case (c.cmd)
        CMD_OBSERVE: begin
          usable = (c.kind == KIND_MGMT || c.kind == KIND_DATA) && c.length >= MIN_FRAME_LEN;
          bssid = '0;
          sta = '0;
          case ({c.to_ds, c.from_ds})
            2'b00: begin
              bssid = c.addr_three;
              sta = (c.addr_two != target) ? c.addr_two : c.addr_one;
            end
            2'b10: begin
              bssid = c.addr_one;
              sta = c.addr_two;
            end
            2'b01: begin
              bssid = c.addr_two;
              sta = c.addr_one;
            end
            default: usable = 0;
          endcase
          if (usable && bssid == target && !sta[GROUP_BIT] && sta != '0 && sta != target) begin
            found = 0;
            for (int i = 0; i < count; i++) begin
              if (!found && addr_tab[i] == sta) begin
                rssi_tab[i] = c.rssi;
                found = 1;
              end
            end
            if (found) begin
              r.ev = EV_REFRESHED;
            end else if (count < TABLE_DEPTH) begin
              addr_tab[count] = sta;
              rssi_tab[count] = c.rssi;
              count++;
              r.ev = EV_ADDED;
            end else begin
              r.ev = EV_FULL;
            end
            r.addr = sta;
            r.rssi = c.rssi;
          end
        end
        CMD_READ: begin
          r.ev = EV_READ;
          if (c.index < count) begin
            r.addr = addr_tab[c.index];
            r.rssi = rssi_tab[c.index];
            r.valid = 1'b1;
          end
        end
        CMD_CLEAR: begin
          count = 0;
          foreach (addr_tab[i]) begin
            addr_tab[i] = '0;
            rssi_tab[i] = '0;
          end
          r.ev = EV_CLEARED;
        end
        default: r.ev = EV_IGNORED;
      endcase
      r.total = TOT_W'(count);
      expected_q.push_back(r);
    endfunction

    function void check_result(input tracker_result_t got);
      tracker_result_t want;
      ev_seen[got.ev]++;
      if (got.ev == EV_READ && got.valid) valid_reads++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: ev %0d addr %012h rssi %0d valid %0b total %0d",
                   got.ev, got.addr, $signed(got.rssi), got.valid, got.total);
        return;
      end
      want = expected_q.pop_front();
      if (got.ev !== want.ev || got.addr !== want.addr || got.rssi !== want.rssi ||
          got.valid !== want.valid || got.total !== want.total) begin
        failures++;
        if (failures <= 10)
          $display("mismatch (exp/got): ev %0d/%0d addr %012h/%012h rssi %0d/%0d valid %0b/%0b total %0d/%0d",
                   want.ev, got.ev, want.addr, got.addr, $signed(want.rssi), $signed(got.rssi),
                   want.valid, got.valid, want.total, got.total);
      end
    endfunction

    function void finish_check();
      if (expected_q.size() != 0) begin
        failures += expected_q.size();
        $display("%0d expected results never arrived", expected_q.size());
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [ADDR_W-1:0]        cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [1:0]               cmd_i;
  logic [1:0]               frame_kind_i;
  logic [11:0]              frame_length_i;
  logic                     to_ds_i;
  logic                     from_ds_i;
  logic [ADDR_W-1:0]        address_one_i;
  logic [ADDR_W-1:0]        address_two_i;
  logic [ADDR_W-1:0]        address_three_i;
  logic signed [RSSI_W-1:0] signal_strength_i;
  logic [IDX_W-1:0]         read_index_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [2:0]               event_res_o;
  logic [ADDR_W-1:0]        station_address_o;
  logic signed [RSSI_W-1:0] station_strength_o;
  logic                     entry_valid_o;
  logic [TOT_W-1:0]         station_total_o;

  station_table_scoreboard tracker = new();
  logic [ADDR_W-1:0]       station_pool [POOL_SIZE];
  logic [ADDR_W-1:0]       current_target = '0;
  bit                      idle_on = 1'b1;
  int unsigned             stall_left = 0;
  int unsigned             target_writes = 0;

  wlan_station_address_tracker #(
    .MAX_STATIONS(TABLE_DEPTH)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .frame_kind_i      (frame_kind_i),
    .frame_length_i    (frame_length_i),
    .to_ds_i           (to_ds_i),
    .from_ds_i         (from_ds_i),
    .address_one_i     (address_one_i),
    .address_two_i     (address_two_i),
    .address_three_i   (address_three_i),
    .signal_strength_i (signal_strength_i),
    .read_index_i      (read_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_res_o       (event_res_o),
    .station_address_o (station_address_o),
    .station_strength_o(station_strength_o),
    .entry_valid_o     (entry_valid_o),
    .station_total_o   (station_total_o)
  );

  always #6 clk_i = ~clk_i;

  // result side: check each transfer, then decide on a receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_result('{event_res_o, station_address_o, station_strength_o,
                             entry_valid_o, station_total_o});
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready_i <= (stall_left == 0);
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", tracker.outstanding());
    $display("wlan_station_address_tracker test failed");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom), $urandom};
  endfunction

  function automatic frame_cmd_t frame_cmd(
    input logic [1:0] cmd, input logic [1:0] kind, input logic [11:0] length,
    input logic to_ds, input logic from_ds, input logic [ADDR_W-1:0] a1,
    input logic [ADDR_W-1:0] a2, input logic [ADDR_W-1:0] a3,
    input logic signed [RSSI_W-1:0] rssi, input logic [IDX_W-1:0] index);
    frame_cmd_t c;
    c.cmd = cmd;
    c.kind = kind;
    c.length = length;
    c.to_ds = to_ds;
    c.from_ds = from_ds;
    c.addr_one = a1;
    c.addr_two = a2;
    c.addr_three = a3;
    c.rssi = rssi;
    c.index = index;
    return c;
  endfunction

  // well-formed header between a station and an access point, random ds mode
  function automatic frame_cmd_t header_for(input logic [ADDR_W-1:0] sta,
                                            input logic [ADDR_W-1:0] bssid);
    frame_cmd_t c;
    c = frame_cmd(CMD_OBSERVE, $urandom_range(0, 1) ? KIND_DATA : KIND_MGMT,
                  12'($urandom_range(MIN_FRAME_LEN, 4095)), 1'b0, 1'b0,
                  rand_addr(), rand_addr(), rand_addr(), 8'($urandom), 5'($urandom));
    case ($urandom_range(0, 2))
      0: begin
        c.addr_three = bssid;
        // address two equal to the bssid moves the station to address one
        if ($urandom_range(0, 9) == 0) begin
          c.addr_two = bssid;
          c.addr_one = sta;
        end else begin
          c.addr_two = sta;
        end
      end
      1: begin
        c.to_ds = 1'b1;
        c.addr_one = bssid;
        c.addr_two = sta;
      end
      default: begin
        c.from_ds = 1'b1;
        c.addr_two = bssid;
        c.addr_one = sta;
      end
    endcase
    return c;
  endfunction

  function automatic void fill_pool();
    logic [ADDR_W-1:0] a;
    foreach (station_pool[i]) begin
      do begin
        a = rand_addr();
        a[GROUP_BIT] = 1'b0;
      end while (a == '0 || a == current_target);
      station_pool[i] = a;
    end
  endfunction

  function automatic frame_cmd_t next_random_item();
    frame_cmd_t c;
    int unsigned pick;
    logic [ADDR_W-1:0] sta;
    pick = $urandom_range(0, 99);
    sta = station_pool[$urandom_range(0, POOL_SIZE - 1)];
    c = header_for(sta, current_target);
    if (pick < 70) return c;
    if (pick < 82) begin
      c.cmd = CMD_READ;
      return c;
    end
    if (pick < 83) begin
      c.cmd = CMD_CLEAR;
      return c;
    end
    // broken headers and noise
    case ($urandom_range(0, 8))
      0: c.kind = 2'($urandom_range(KIND_OTHER, 3));
      1: c.length = 12'($urandom_range(0, MIN_FRAME_LEN - 1));
      2: begin
        c.to_ds = 1'b1;
        c.from_ds = 1'b1;
      end
      3: c = header_for(sta, rand_addr());
      4: c = header_for(sta | (48'd1 << GROUP_BIT), current_target);
      5: c = header_for('0, current_target);
      6: c = header_for(current_target, current_target);
      7: c.cmd = CMD_UNUSED;
      default: c = frame_cmd(2'($urandom), 2'($urandom), 12'($urandom), 1'($urandom),
                             1'($urandom), rand_addr(), rand_addr(), rand_addr(),
                             8'($urandom), 5'($urandom));
    endcase
    return c;
  endfunction

  task automatic send_frame_cmd(input frame_cmd_t c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c.cmd;
    frame_kind_i <= c.kind;
    frame_length_i <= c.length;
    to_ds_i <= c.to_ds;
    from_ds_i <= c.from_ds;
    address_one_i <= c.addr_one;
    address_two_i <= c.addr_two;
    address_three_i <= c.addr_three;
    signal_strength_i <= c.rssi;
    read_index_i <= c.index;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_transfer(c);
  endtask

  // target writes only once every outstanding result is back
  task automatic write_target(input logic [ADDR_W-1:0] value);
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    current_target = value;
    tracker.set_target(value);
    target_writes++;
    fill_pool();
  endtask

  initial begin
    logic [ADDR_W-1:0] tgt;
    logic [ADDR_W-1:0] sta_a;
    logic [ADDR_W-1:0] sta_b;
    logic [ADDR_W-1:0] sta_c;
    logic [ADDR_W-1:0] sta_d;
    logic [ADDR_W-1:0] sta_e;
    logic [ADDR_W-1:0] phase_targets [4];
    int unsigned wait_cycles;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    cmd_i = CMD_OBSERVE;
    frame_kind_i = KIND_MGMT;
    frame_length_i = '0;
    to_ds_i = 1'b0;
    from_ds_i = 1'b0;
    address_one_i = '0;
    address_two_i = '0;
    address_three_i = '0;
    signal_strength_i = '0;
    read_index_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tgt = 48'h02_1A_2B_3C_4D_5E;
    sta_a = 48'h0A_00_00_00_00_01;
    sta_b = 48'h3C_11_22_33_44_55;
    sta_c = 48'h7E_DE_AD_BE_EF_00;
    sta_d = 48'hFE_FF_FF_FF_FF_FF;
    sta_e = 48'h00_00_00_00_00_01;
    write_target(tgt);

    send_frame_cmd(frame_cmd(CMD_READ, KIND_MGMT, 12'd0, 0, 0, '0, '0, '0, 8'sd0, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_MGMT, MIN_FRAME_LEN, 0, 0, '1, sta_a, tgt,
                             -8'sd40, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, 12'hFFF, 1, 0, tgt, sta_b, rand_addr(),
                             8'sd127, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, 12'd100, 0, 1, sta_c, tgt, '0,
                             -8'sd128, 5'd0));
    // station taken from address one since address two is the bssid
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_MGMT, 12'd60, 0, 0, sta_d, tgt, tgt,
                             -8'sd70, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, 12'd30, 1, 0, tgt, sta_e, '0,
                             8'sd0, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, 12'd30, 1, 0, tgt, sta_a, '0,
                             -8'sd1, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, 12'd80, 1, 1, tgt, sta_c, tgt,
                             -8'sd50, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_OTHER, 12'd80, 1, 0, tgt, sta_c, '0,
                             -8'sd50, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, 2'd3, 12'd80, 1, 0, tgt, sta_c, '0,
                             -8'sd50, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, MIN_FRAME_LEN - 12'd1, 1, 0, tgt,
                             sta_c, '0, -8'sd50, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_MGMT, 12'd0, 1, 0, tgt, sta_c, '0,
                             -8'sd50, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, 12'd80, 1, 0, tgt ^ 48'd1, sta_c, '0,
                             -8'sd50, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, 12'd80, 1, 0, tgt,
                             sta_a | (48'd1 << GROUP_BIT), '0, -8'sd50, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, 12'd80, 1, 0, tgt, '0, '0,
                             -8'sd50, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, 12'd80, 0, 1, tgt, tgt, '0,
                             -8'sd50, 5'd0));
    send_frame_cmd(frame_cmd(CMD_UNUSED, KIND_DATA, 12'd80, 1, 0, tgt, sta_c, '0,
                             -8'sd50, 5'd3));
    send_frame_cmd(frame_cmd(CMD_READ, KIND_MGMT, 12'd0, 0, 0, '0, '0, '0, 8'sd0, 5'd0));
    send_frame_cmd(frame_cmd(CMD_READ, KIND_MGMT, 12'd0, 0, 0, '0, '0, '0, 8'sd0, 5'd4));
    send_frame_cmd(frame_cmd(CMD_READ, KIND_MGMT, 12'd0, 0, 0, '0, '0, '0, 8'sd0, 5'd5));
    send_frame_cmd(frame_cmd(CMD_READ, KIND_MGMT, 12'd0, 0, 0, '0, '0, '0, 8'sd0, 5'd31));
    send_frame_cmd(frame_cmd(CMD_CLEAR, KIND_MGMT, 12'd0, 0, 0, '0, '0, '0, 8'sd0, 5'd0));
    send_frame_cmd(frame_cmd(CMD_READ, KIND_MGMT, 12'd0, 0, 0, '0, '0, '0, 8'sd0, 5'd0));
    send_frame_cmd(frame_cmd(CMD_OBSERVE, KIND_DATA, 12'd40, 1, 0, tgt, sta_b, '0,
                             -8'sd90, 5'd0));

    phase_targets[0] = '0;
    phase_targets[1] = '1;
    phase_targets[2] = rand_addr();
    phase_targets[3] = rand_addr();
    foreach (phase_targets[p]) begin
      write_target(phase_targets[p]);
      // the last stretch runs at full rate on both sides
      if (p == 3) idle_on = 1'b0;
      repeat (PHASE_ITEMS) send_frame_cmd(next_random_item());
    end

    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (tracker.outstanding() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (TABLE_DEPTH + 4) @(posedge clk_i);
    tracker.finish_check();
    $display("%0d transfers under %0d target settings; added %0d, refreshed %0d, full %0d",
             tracker.transfers, target_writes, tracker.ev_seen[EV_ADDED],
             tracker.ev_seen[EV_REFRESHED], tracker.ev_seen[EV_FULL]);
    $display("reads %0d (%0d hit), clears %0d, ignored %0d, failures %0d",
             tracker.ev_seen[EV_READ], tracker.valid_reads, tracker.ev_seen[EV_CLEARED],
             tracker.ev_seen[EV_IGNORED], tracker.failures);
    if (tracker.failures == 0) begin
      $display("wlan_station_address_tracker test passed");
    end else begin
      $display("wlan_station_address_tracker test failed");
    end
    $finish;
  end

endmodule
